// File: design/qse_pkg.sv
package qse_pkg;

  localparam int MaxItems = 64;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = IdxW + 1;
  localparam int DataW = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             is_last;
  } beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_RANGE,
    S_PIV,
    S_SCAN_L,
    S_SCAN_R,
    S_SWAP,
    S_FIN,
    S_PUSH_B,
    S_OUT_PRIME,
    S_OUT
  } state_t;

  function automatic logic lt_signed(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    lt_signed = $signed(a) < $signed(b);
  endfunction

endpackage

// File: design/qse_if.sv
interface qse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        is_last;
  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface qse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_value;
  logic        is_last_res;
  modport source (output valid, output sorted_value, output is_last_res, input ready);
  modport sink (input valid, input sorted_value, input is_last_res, output ready);
endinterface

// File: design/qse_front.sv
module qse_front import qse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  qse_in_if.sink in_ch,
  output logic  q_valid,
  input  logic  q_ready,
  output beat_t q_data
);

  beat_t buf0, buf1;
  logic  v0, v1;

  assign in_ch.ready = !v1;
  assign q_valid = v0;
  assign q_data = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        if (v1) begin
          buf0 <= buf1;
          v1 <= 1'b0;
        end else if (in_ch.valid && in_ch.ready) begin
          buf0 <= '{value: in_ch.value, is_last: in_ch.is_last};
        end else begin
          v0 <= 1'b0;
        end
      end else if (in_ch.valid && in_ch.ready) begin
        if (v0) begin
          buf1 <= '{value: in_ch.value, is_last: in_ch.is_last};
          v1 <= 1'b1;
        end else begin
          buf0 <= '{value: in_ch.value, is_last: in_ch.is_last};
          v0 <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/qse_back.sv
module qse_back import qse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  beat_t     q_data,
  qse_out_if.source out_ch
);

  logic [DataW-1:0] mem [MaxItems];
  logic [2*IdxW-1:0] stk [MaxItems];

  state_t state, state_next;
  cnt_t count, sp;
  idx_t lo, hi, left, right, piv, oidx;
  logic [DataW-1:0] pval, lval, rdata;
  logic [2*IdxW-1:0] stk_q;
  logic ovalid;
  logic [DataW-1:0] odata;
  logic olast;

  idx_t rd_addr, wr_addr;
  logic wr_en;
  logic [DataW-1:0] wr_data;
  logic stk_we;
  idx_t stk_waddr;
  logic [2*IdxW-1:0] stk_wdata;
  idx_t stk_lo, stk_hi;
  cnt_t midsum;
  cnt_t count_inc;
  logic out_free, out_end, push_a, push_b;

  assign q_ready = (state == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.sorted_value = odata;
  assign out_ch.is_last_res = olast;
  assign stk_lo = stk_q[2*IdxW-1:IdxW];
  assign stk_hi = stk_q[IdxW-1:0];
  assign midsum = cnt_t'(stk_lo) + cnt_t'(stk_hi);
  assign count_inc = (count < cnt_t'(MaxItems)) ? count + cnt_t'(1) : count;
  assign out_free = !ovalid || out_ch.ready;
  assign out_end = (cnt_t'(oidx) + cnt_t'(1) == count);
  assign push_a = (cnt_t'(right) > cnt_t'(lo) + cnt_t'(1)) && (sp < cnt_t'(MaxItems));
  assign push_b = (cnt_t'(right) + cnt_t'(1) < cnt_t'(hi)) && (sp < cnt_t'(MaxItems));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_waddr] <= stk_wdata;
    stk_q <= stk[idx_t'(sp - cnt_t'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr = oidx;
    wr_en = 1'b0;
    wr_addr = idx_t'(count);
    wr_data = q_data.value;
    stk_we = 1'b0;
    stk_waddr = idx_t'(sp);
    stk_wdata = {lo, right - idx_t'(1)};
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          wr_en = (count < cnt_t'(MaxItems));
          if (q_data.is_last) begin
            stk_we = 1'b1;
            stk_waddr = '0;
            stk_wdata = {idx_t'(0), idx_t'(count_inc - cnt_t'(1))};
            state_next = S_POP;
          end
        end
      end
      S_POP: begin
        state_next = (sp == '0) ? S_OUT_PRIME : S_RANGE;
      end
      S_RANGE: begin
        rd_addr = midsum[CntW-1:1];
        if (stk_lo >= stk_hi || cnt_t'(stk_hi) >= count) state_next = S_POP;
        else state_next = S_PIV;
      end
      S_PIV: begin
        rd_addr = left;
        state_next = S_SCAN_L;
      end
      S_SCAN_L: begin
        if (left < right && lt_signed(rdata, pval)) begin
          rd_addr = left + idx_t'(1);
        end else if (left < right) begin
          rd_addr = right;
          state_next = S_SCAN_R;
        end else begin
          wr_en = 1'b1;
          wr_addr = piv;
          wr_data = rdata;
          state_next = S_FIN;
        end
      end
      S_SCAN_R: begin
        if (left < right && !lt_signed(rdata, pval)) begin
          rd_addr = right - idx_t'(1);
        end else if (left < right) begin
          wr_en = 1'b1;
          wr_addr = left;
          wr_data = rdata;
          state_next = S_SWAP;
        end else begin
          wr_en = 1'b1;
          wr_addr = piv;
          wr_data = rdata;
          state_next = S_FIN;
        end
      end
      S_SWAP: begin
        wr_en = 1'b1;
        wr_addr = right;
        wr_data = lval;
        rd_addr = left;
        state_next = S_SCAN_L;
      end
      S_FIN: begin
        wr_en = 1'b1;
        wr_addr = right;
        wr_data = pval;
        stk_we = push_a;
        stk_waddr = idx_t'(sp);
        stk_wdata = {lo, right - idx_t'(1)};
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        stk_we = push_b;
        stk_waddr = idx_t'(sp);
        stk_wdata = {right + idx_t'(1), hi};
        state_next = S_POP;
      end
      S_OUT_PRIME: begin
        rd_addr = '0;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          rd_addr = oidx + idx_t'(1);
          if (out_end) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sp <= '0;
      ovalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            count <= count_inc;
            if (q_data.is_last) begin
              sp <= (count_inc >= cnt_t'(2)) ? cnt_t'(1) : cnt_t'(0);
            end
          end
        end
        S_POP: begin
          if (sp != '0) sp <= sp - cnt_t'(1);
        end
        S_RANGE: begin
          lo <= stk_lo;
          hi <= stk_hi;
          left <= stk_lo;
          right <= stk_hi;
          piv <= midsum[CntW-1:1];
        end
        S_PIV: pval <= rdata;
        S_SCAN_L: begin
          if (left < right && lt_signed(rdata, pval)) left <= left + idx_t'(1);
          else lval <= rdata;
        end
        S_SCAN_R: begin
          if (left < right && !lt_signed(rdata, pval)) right <= right - idx_t'(1);
          else if (left < right && left == piv) piv <= right;
        end
        S_FIN: begin
          if (push_a) sp <= sp + cnt_t'(1);
        end
        S_PUSH_B: begin
          if (push_b) sp <= sp + cnt_t'(1);
        end
        S_OUT_PRIME: oidx <= '0;
        S_OUT: begin
          if (out_free) begin
            odata <= rdata;
            olast <= out_end;
            oidx <= oidx + idx_t'(1);
            if (out_end) count <= '0;
          end
        end
        default: ;
      endcase
      if (state == S_OUT && out_free) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
    end
  end

endmodule

// File: design/quicksort_engine.sv
// Channel  Dir  Payload
// in_ch    in   value, is_last
// out_ch   out  sorted_value, is_last_res
// Beats are written to the store while idle; a two-beat queue sits in front of the store.
// Sorting partitions each range with a left and a right scan, swapping misplaced pairs.
// Output is primed by one store read, then one beat per cycle while out_ch is ready.
// Beats are taken only while loading, so in_ch stalls once the queue fills during a sort.
// Reset is synchronous and clears the control state only.
module quicksort_engine import qse_pkg::*; (
  input logic clk,
  input logic rst,
  qse_in_if.sink in_ch,
  qse_out_if.source out_ch
);

  logic  q_valid, q_ready;
  beat_t q_data;

  qse_front u_front (.clk, .rst, .in_ch, .q_valid, .q_ready, .q_data);
  qse_back  u_back  (.clk, .rst, .q_valid, .q_ready, .q_data, .out_ch);

endmodule

// File: design/qse_checker.sv
module qse_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [31:0] out_value
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("output beat changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last ##1 out_valid |->
      $signed(out_value) >= $signed($past(out_value)) || !$past(out_valid && out_ready))
    else $error("output not ascending");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_last))
    else $error("last flag changed while stalled");

endmodule

bind quicksort_engine qse_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.is_last_res), .out_value(out_ch.sorted_value)
);

// File: bench/quicksort_engine_check.sv
module quicksort_engine_check import qse_pkg::*; (
  input logic clk,
  input logic rst,
  qse_in_if.sink in_mon,
  qse_out_if.sink out_mon,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DataW-1:0] loaded_set[$];
  logic [DataW-1:0] sorted_due[$];
  logic last_due[$];

  function automatic int split_range(ref logic [DataW-1:0] a[$], input int lo, input int hi);
    int left;
    int right;
    int piv;
    logic [DataW-1:0] t;
    left = lo;
    right = hi;
    piv = (lo + hi) / 2;
    while (left < right) begin
      while (left < right && $signed(a[left]) < $signed(a[piv])) left++;
      while (left < right && !($signed(a[right]) < $signed(a[piv]))) right--;
      if (left < right) begin
        t = a[left];
        a[left] = a[right];
        a[right] = t;
        if (left == piv) piv = right;
      end
    end
    t = a[piv];
    a[piv] = a[right];
    a[right] = t;
    return right;
  endfunction

  task automatic sort_and_queue();
    int lo_stack[$];
    int hi_stack[$];
    int lo;
    int hi;
    int p;
    int n;
    n = loaded_set.size();
    if (n >= 2) begin
      lo_stack.push_back(0);
      hi_stack.push_back(n - 1);
    end
    while (lo_stack.size() > 0) begin
      lo = lo_stack.pop_back();
      hi = hi_stack.pop_back();
      if (lo >= hi) continue;
      p = split_range(loaded_set, lo, hi);
      if (p > lo + 1) begin
        lo_stack.push_back(lo);
        hi_stack.push_back(p - 1);
      end
      if (p + 1 < hi) begin
        lo_stack.push_back(p + 1);
        hi_stack.push_back(hi);
      end
    end
    for (int k = 0; k < n; k++) begin
      sorted_due.push_back(loaded_set[k]);
      last_due.push_back(k == n - 1);
    end
    loaded_set.delete();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loaded_set.delete();
      sorted_due.delete();
      last_due.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_due.size() == 0) begin
          $error("sorted_value: expected none, got %0d", $signed(out_mon.sorted_value));
          errors <= errors + 1;
        end else begin
          if (out_mon.sorted_value !== sorted_due[0]) begin
            $error("sorted_value: expected %0d, got %0d", $signed(sorted_due[0]),
                   $signed(out_mon.sorted_value));
            errors <= errors + 1;
          end else if (out_mon.is_last_res !== last_due[0]) begin
            $error("is_last_res: expected %0b, got %0b", last_due[0], out_mon.is_last_res);
            errors <= errors + 1;
          end
          void'(sorted_due.pop_front());
          void'(last_due.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (loaded_set.size() < MaxItems) loaded_set.push_back(in_mon.value);
        if (in_mon.is_last) sort_and_queue();
      end
      pending <= sorted_due.size();
    end
  end

endmodule

// File: bench/quicksort_engine_test.sv
module quicksort_engine_test import qse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int errors;
  int pending;
  int hold_off = 0;

  qse_in_if in_ch ();
  qse_out_if out_ch ();

  quicksort_engine i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  quicksort_engine_check i_check (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                                  .errors(errors), .pending(pending));

  always #10 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  function automatic logic [DataW-1:0] pick_value(input int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      3: return -$urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic [DataW-1:0] v, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_set(input int n, input int mode);
    for (int k = 0; k < n; k++) send_beat(pick_value(mode == 9 ? $urandom_range(6) : mode),
                                          k == n - 1);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (1) begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else begin
        out_ch.ready <= ($urandom_range(4) != 0) || (gap_len() == 0);
        @(posedge clk);
      end
    end
  end

  initial begin
    #5ms;
    $display("quicksort_engine_test: errors");
    $finish;
  end

  initial begin
    int total;
    int n;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.is_last = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_set(1, 0);
    send_set(2, 1);
    send_set(4, 0);
    send_set(6, 2);
    send_set(8, 9);
    hold_off = 400;
    send_set(MaxItems, 4);
    send_set(MaxItems + 5, 9);
    total = 21 + 2 * MaxItems + 5;
    while (total < 250) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(MaxItems, 20) : $urandom_range(12, 1);
      send_set(n, $urandom_range(3) == 0 ? 2 : 9);
      total += n;
    end
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("quicksort_engine_test: clean");
    end else begin
      $display("quicksort_engine_test: errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/qse_pkg.sv
design/qse_if.sv
design/qse_front.sv
design/qse_back.sv
design/quicksort_engine.sv
design/qse_checker.sv
bench/quicksort_engine_check.sv
bench/quicksort_engine_test.sv
